// ===== hw/rtl/mjpid_pkg.sv =====
package mjpid_pkg;

   localparam int NUM_JOINTS_DEF = 8;
   localparam int JOINT_W = 3;
   localparam int Q_W = 32;
   localparam int RATE_W = 16;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   localparam logic signed [63:0] Q_MAX_EXT = 64'sh0000_0000_7fff_ffff;
   localparam logic signed [63:0] Q_MIN_EXT = 64'shffff_ffff_8000_0000;

   function automatic logic signed [Q_W-1:0] sat_q(input logic signed [63:0] x);
      logic signed [Q_W-1:0] r;
      if (x > Q_MAX_EXT) begin
         r = Q_MAX_EXT[Q_W-1:0];
      end else if (x < Q_MIN_EXT) begin
         r = Q_MIN_EXT[Q_W-1:0];
      end else begin
         r = x[Q_W-1:0];
      end
      return r;
   endfunction

endpackage

// ===== hw/rtl/mjpid_req_if.sv =====
interface mjpid_req_if
   import mjpid_pkg::*;
();
   logic                    valid;
   logic                    ready;
   logic                    cmd;
   logic [JOINT_W-1:0]      joint;
   logic signed [Q_W-1:0]   value;
   logic signed [Q_W-1:0]   bias_torque;

   modport source (output valid, output cmd, output joint, output value,
                   output bias_torque, input ready);
   modport sink (input valid, input cmd, input joint, input value,
                 input bias_torque, output ready);
endinterface

// ===== hw/rtl/mjpid_rsp_if.sv =====
interface mjpid_rsp_if
   import mjpid_pkg::*;
();
   logic                    valid;
   logic                    ready;
   logic [JOINT_W-1:0]      joint_out;
   logic signed [Q_W-1:0]   drive;

   modport source (output valid, output joint_out, output drive, input ready);
   modport sink (input valid, input joint_out, input drive, output ready);
endinterface

// ===== hw/rtl/multi_joint_pid_controller.sv =====
// Per-joint PID controller in signed Q16.16. A command word updates one joint's
// reference according to control_mode; a tick word brings a measured position and
// a bias torque and produces one drive word on the response channel. The per-joint
// state lives in a single-port memory read when a word is taken and written back
// when a word has changed it. The block takes no new word until the current one is
// finished. A position- or velocity-mode tick runs the 32-step bit-serial divider
// by sample_rate followed by three passes through the shared gain multiplier; a
// velocity-mode command runs the same divider, and all other in-range words skip it.
// A word addressing a joint at or above NUM_JOINTS is taken and dropped without a
// response. A finished response waits in an output register while the next word
// is taken; a tick that finishes while the previous response still waits stalls
// until that response has been accepted.
module multi_joint_pid_controller
   import mjpid_pkg::*;
#(
   parameter int NUM_JOINTS = NUM_JOINTS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   mjpid_req_if.sink              req,
   mjpid_rsp_if.source            rsp,
   input  logic                   psel,
   input  logic                   penable,
   input  logic                   pwrite,
   input  logic [CSR_ADDR_W-1:0]  paddr,
   input  logic [CSR_DATA_W-1:0]  pwdata,
   output logic [CSR_DATA_W-1:0]  prdata,
   output logic                   pready
);

   localparam int JW = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;

   localparam logic [2:0] REG_CONTROL_MODE = 3'd0;
   localparam logic [2:0] REG_KP           = 3'd1;
   localparam logic [2:0] REG_KI           = 3'd2;
   localparam logic [2:0] REG_KD           = 3'd3;
   localparam logic [2:0] REG_SAMPLE_RATE  = 3'd4;

   localparam logic [1:0] MODE_POSITION = 2'd0;
   localparam logic [1:0] MODE_VELOCITY = 2'd1;
   localparam logic [1:0] MODE_TORQUE   = 2'd2;

   localparam logic [RATE_W-1:0] RATE_RESET = 16'd1000;

   typedef struct packed {
      logic [Q_W-1:0] ref_pos;
      logic [Q_W-1:0] ref_torque;
      logic [Q_W-1:0] integral;
      logic [Q_W-1:0] prev_err;
   } joint_state_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_LOAD,
      S_DIV,
      S_DERIV,
      S_MUL,
      S_SUM,
      S_OUTP
   } state_type;

   state_type               state_ff, state_in;
   logic [1:0]              mode_ff, mode_in;
   logic [Q_W-1:0]          kp_ff, kp_in;
   logic [Q_W-1:0]          ki_ff, ki_in;
   logic [Q_W-1:0]          kd_ff, kd_in;
   logic [RATE_W-1:0]       rate_ff, rate_in;
   logic [NUM_JOINTS-1:0]   vld_ff, vld_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [JOINT_W-1:0]      rsp_joint_ff, rsp_joint_in;
   logic signed [Q_W-1:0]   rsp_drive_ff, rsp_drive_in;

   logic                    cmd_ff, cmd_in;
   logic [JOINT_W-1:0]      joint_ff, joint_in;
   logic [JW-1:0]           addr_ff, addr_in;
   logic signed [Q_W-1:0]   val_ff, val_in;
   logic signed [Q_W-1:0]   bias_ff, bias_in;
   joint_state_type         rd_ff;
   joint_state_type         work_ff, work_in;
   logic signed [Q_W-1:0]   err_ff, err_in;
   logic                    neg_ff, neg_in;
   logic [Q_W-1:0]          dq_ff, dq_in;
   logic [RATE_W-1:0]       rem_ff, rem_in;
   logic [4:0]              cnt_ff, cnt_in;
   logic signed [63:0]      prod_ff, prod_in;
   logic signed [49:0]      acc_ff, acc_in;
   logic signed [Q_W-1:0]   deriv_ff, deriv_in;
   logic signed [Q_W-1:0]   drive_ff, drive_in;

   joint_state_type         mem [NUM_JOINTS];
   logic                    mem_we;
   joint_state_type         mem_wdata;

   logic                    req_fire;
   logic [JW-1:0]           req_addr;
   logic                    req_in_range;
   logic                    csr_write;
   logic [2:0]              csr_index;
   logic [RATE_W-1:0]       rate_eff;
   joint_state_type         cur;
   logic signed [Q_W-1:0]   err_load;
   logic signed [Q_W-1:0]   div_src;
   logic [RATE_W:0]         div_shift;
   logic                    div_ge;
   logic [Q_W-1:0]          quo;
   logic signed [Q_W:0]     quo_signed;
   logic signed [Q_W-1:0]   div_base;
   logic signed [Q_W-1:0]   div_sum;
   logic signed [Q_W:0]     diff;
   logic signed [RATE_W:0]  rate_s;
   logic signed [49:0]      dprod;
   logic signed [Q_W:0]     gain_s;
   logic signed [Q_W-1:0]   mul_op;

   assign req_fire     = req.valid && req.ready;
   assign req_addr     = JW'(req.joint);
   assign req_in_range = int'(req.joint) < NUM_JOINTS;
   assign req.ready    = (state_ff == S_IDLE);

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.joint_out = rsp_joint_ff;
   assign rsp.drive     = rsp_drive_ff;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign csr_index = paddr[4:2];
   assign rate_eff  = (rate_ff == '0) ? RATE_W'(1) : rate_ff;

   always_comb begin
      case (csr_index)
         REG_CONTROL_MODE: prdata = CSR_DATA_W'(mode_ff);
         REG_KP:           prdata = kp_ff;
         REG_KI:           prdata = ki_ff;
         REG_KD:           prdata = kd_ff;
         REG_SAMPLE_RATE:  prdata = CSR_DATA_W'(rate_ff);
         default:          prdata = '0;
      endcase
   end

   always_comb begin
      mode_in = mode_ff;
      kp_in   = kp_ff;
      ki_in   = ki_ff;
      kd_in   = kd_ff;
      rate_in = rate_ff;
      if (csr_write) begin
         case (csr_index)
            REG_CONTROL_MODE: mode_in = pwdata[1:0];
            REG_KP:           kp_in   = pwdata;
            REG_KI:           ki_in   = pwdata;
            REG_KD:           kd_in   = pwdata;
            REG_SAMPLE_RATE:  rate_in = pwdata[RATE_W-1:0];
            default:          mode_in = mode_ff;
         endcase
      end
   end

   assign cur      = vld_ff[addr_ff] ? rd_ff : '0;
   assign err_load = sat_q(64'($signed(cur.ref_pos)) - 64'(val_ff));
   assign div_src  = cmd_ff ? val_ff : err_load;

   assign div_shift  = {rem_ff, dq_ff[Q_W-1]};
   assign div_ge     = div_shift >= {1'b0, rate_eff};
   assign quo        = {dq_ff[Q_W-2:0], div_ge};
   assign quo_signed = neg_ff ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
   assign div_base   = cmd_ff ? $signed(work_ff.ref_pos) : $signed(work_ff.integral);
   assign div_sum    = sat_q(64'(div_base) + 64'(quo_signed));

   assign diff   = 33'(err_ff) - 33'($signed(work_ff.prev_err));
   assign rate_s = $signed({1'b0, rate_eff});
   assign dprod  = diff * rate_s;

   always_comb begin
      case (cnt_ff[1:0])
         2'd1: begin
            gain_s = $signed({1'b0, ki_ff});
            mul_op = $signed(work_ff.integral);
         end
         2'd2: begin
            gain_s = $signed({1'b0, kd_ff});
            mul_op = deriv_ff;
         end
         default: begin
            gain_s = $signed({1'b0, kp_ff});
            mul_op = err_ff;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_joint_in = rsp_joint_ff;
      rsp_drive_in = rsp_drive_ff;
      cmd_in       = cmd_ff;
      joint_in     = joint_ff;
      addr_in      = addr_ff;
      val_in       = val_ff;
      bias_in      = bias_ff;
      work_in      = work_ff;
      err_in       = err_ff;
      neg_in       = neg_ff;
      dq_in        = dq_ff;
      rem_in       = rem_ff;
      cnt_in       = cnt_ff;
      prod_in      = prod_ff;
      acc_in       = acc_ff;
      deriv_in     = deriv_ff;
      drive_in     = drive_ff;
      mem_we       = 1'b0;
      mem_wdata    = work_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               cmd_in   = req.cmd;
               joint_in = req.joint;
               addr_in  = req_addr;
               val_in   = req.value;
               bias_in  = req.bias_torque;
               if (req_in_range) begin
                  state_in = S_LOAD;
               end
            end
         end
         S_LOAD: begin
            work_in = cur;
            neg_in  = div_src[Q_W-1];
            dq_in   = div_src[Q_W-1] ? Q_W'(-div_src) : div_src;
            rem_in  = '0;
            cnt_in  = '0;
            if (cmd_ff) begin
               case (mode_ff)
                  MODE_POSITION: begin
                     mem_wdata         = cur;
                     mem_wdata.ref_pos = val_ff;
                     mem_we            = 1'b1;
                     state_in          = S_IDLE;
                  end
                  MODE_VELOCITY: state_in = S_DIV;
                  MODE_TORQUE: begin
                     mem_wdata            = cur;
                     mem_wdata.ref_torque = val_ff;
                     mem_we               = 1'b1;
                     state_in             = S_IDLE;
                  end
                  default: state_in = S_IDLE;
               endcase
            end else begin
               case (mode_ff)
                  MODE_POSITION, MODE_VELOCITY: begin
                     err_in   = err_load;
                     state_in = S_DIV;
                  end
                  MODE_TORQUE: begin
                     drive_in = sat_q(64'(bias_ff) + 64'($signed(cur.ref_torque)));
                     state_in = S_OUTP;
                  end
                  default: begin
                     drive_in = '0;
                     state_in = S_OUTP;
                  end
               endcase
            end
         end
         S_DIV: begin
            rem_in = div_ge ? RATE_W'(div_shift - {1'b0, rate_eff}) : div_shift[RATE_W-1:0];
            dq_in  = quo;
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) begin
               if (cmd_ff) begin
                  mem_wdata         = work_ff;
                  mem_wdata.ref_pos = div_sum;
                  mem_we            = 1'b1;
                  state_in          = S_IDLE;
               end else begin
                  work_in.integral = div_sum;
                  state_in         = S_DERIV;
               end
            end
         end
         S_DERIV: begin
            deriv_in = sat_q(64'(dprod));
            cnt_in   = '0;
            acc_in   = '0;
            state_in = S_MUL;
         end
         S_MUL: begin
            prod_in = gain_s * mul_op;
            if (cnt_ff != 5'd0) begin
               acc_in = acc_ff + 50'(prod_ff >>> 16);
            end
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd3) begin
               state_in = S_SUM;
            end
         end
         S_SUM: begin
            drive_in          = sat_q(64'(acc_ff));
            mem_wdata         = work_ff;
            mem_wdata.prev_err = err_ff;
            mem_we            = 1'b1;
            state_in          = S_OUTP;
         end
         S_OUTP: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in = 1'b1;
               rsp_joint_in = joint_ff;
               rsp_drive_in = drive_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      vld_in = vld_ff;
      if (mem_we) begin
         vld_in[addr_ff] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         vld_ff       <= '0;
         mode_ff      <= MODE_POSITION;
         kp_ff        <= '0;
         ki_ff        <= '0;
         kd_ff        <= '0;
         rate_ff      <= RATE_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_joint_ff <= rsp_joint_in;
         rsp_drive_ff <= rsp_drive_in;
         vld_ff       <= vld_in;
         mode_ff      <= mode_in;
         kp_ff        <= kp_in;
         ki_ff        <= ki_in;
         kd_ff        <= kd_in;
         rate_ff      <= rate_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff   <= cmd_in;
      joint_ff <= joint_in;
      addr_ff  <= addr_in;
      val_ff   <= val_in;
      bias_ff  <= bias_in;
      work_ff  <= work_in;
      err_ff   <= err_in;
      neg_ff   <= neg_in;
      dq_ff    <= dq_in;
      rem_ff   <= rem_in;
      cnt_ff   <= cnt_in;
      prod_ff  <= prod_in;
      acc_ff   <= acc_in;
      deriv_ff <= deriv_in;
      drive_ff <= drive_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[addr_ff] <= mem_wdata;
      end
      if (req_fire) begin
         rd_ff <= mem[req_addr];
      end
   end

endmodule

// ===== tb/tb_multi_joint_pid_controller.sv =====
module tb_multi_joint_pid_controller;
   import mjpid_pkg::*;

   typedef enum logic [1:0] {
      MODE_POSITION = 2'd0,
      MODE_VELOCITY = 2'd1,
      MODE_TORQUE   = 2'd2,
      MODE_UNKNOWN  = 2'd3
   } ctrl_mode_type;

   typedef enum int {
      REG_MODE = 0,
      REG_KP   = 1,
      REG_KI   = 2,
      REG_KD   = 3,
      REG_RATE = 4
   } csr_index_type;

   typedef enum bit {
      CMD_TICK = 1'b0,
      CMD_SET  = 1'b1
   } word_kind_type;

   typedef struct packed {
      logic [JOINT_W-1:0] joint;
      logic [Q_W-1:0]     drive;
   } drive_word_type;

   localparam logic [Q_W-1:0] Q_HI = 32'h7fff_ffff;
   localparam logic [Q_W-1:0] Q_LO = 32'h8000_0000;
   localparam int RANDOM_WORDS = 1900;
   localparam int SETTLE_CYCLES = 64;
   localparam int DRAIN_CYCLES = 64;
   localparam int STALL_LIMIT = 2000;

   class pid_scoreboard_type;
      ctrl_mode_type  mode;
      logic [Q_W-1:0] kp;
      logic [Q_W-1:0] ki;
      logic [Q_W-1:0] kd;
      logic [15:0]    rate;
      longint         ref_pos[NUM_JOINTS_DEF];
      longint         ref_trq[NUM_JOINTS_DEF];
      longint         integ[NUM_JOINTS_DEF];
      longint         prev_err[NUM_JOINTS_DEF];
      drive_word_type drive_q[$];
      int             errors;

      function new();
         mode = MODE_POSITION;
         kp = '0;
         ki = '0;
         kd = '0;
         rate = 16'd1000;
         errors = 0;
         for (int i = 0; i < NUM_JOINTS_DEF; i++) begin
            ref_pos[i] = 0;
            ref_trq[i] = 0;
            integ[i] = 0;
            prev_err[i] = 0;
         end
      endfunction

      function void write_reg(csr_index_type idx, logic [31:0] data);
         case (idx)
            REG_MODE: begin
               mode = ctrl_mode_type'(data[1:0]);
            end
            REG_KP: begin
               kp = data;
            end
            REG_KI: begin
               ki = data;
            end
            REG_KD: begin
               kd = data;
            end
            default: begin
               rate = data[15:0];
            end
         endcase
      endfunction

      function longint clamp_q(longint x);
         longint r;
         r = x;
         if (x > longint'(32'sh7fff_ffff)) r = longint'(32'sh7fff_ffff);
         if (x < longint'(32'sh8000_0000)) r = longint'(32'sh8000_0000);
         return r;
      endfunction

      // Q16.16 gain times Q16.16 operand, scaled back by 16 bits with a floor.
      function longint gain_product(logic [Q_W-1:0] gain, longint operand);
         longint g;
         g = {32'h0, gain};
         return (g * operand) >>> 16;
      endfunction

      function void note_word(word_kind_type kind, logic [JOINT_W-1:0] j,
                              logic signed [Q_W-1:0] val, logic signed [Q_W-1:0] bias);
         longint v;
         longint b;
         longint r;
         longint err;
         longint deriv;
         longint drv;
         drive_word_type w;
         v = val;
         b = bias;
         r = (rate == 16'd0) ? 1 : longint'(rate);
         drv = 0;
         if (kind == CMD_SET) begin
            case (mode)
               MODE_POSITION: begin
                  ref_pos[j] = v;
               end
               MODE_VELOCITY: begin
                  ref_pos[j] = clamp_q(ref_pos[j] + v / r);
               end
               MODE_TORQUE: begin
                  ref_trq[j] = v;
               end
               default: begin
               end
            endcase
            return;
         end
         if (mode == MODE_POSITION || mode == MODE_VELOCITY) begin
            err = clamp_q(ref_pos[j] - v);
            integ[j] = clamp_q(integ[j] + err / r);
            deriv = clamp_q((err - prev_err[j]) * r);
            drv = clamp_q(gain_product(kp, err) + gain_product(ki, integ[j])
                          + gain_product(kd, deriv));
            prev_err[j] = err;
         end else if (mode == MODE_TORQUE) begin
            drv = clamp_q(b + ref_trq[j]);
         end
         w.joint = j;
         w.drive = drv[Q_W-1:0];
         drive_q.insert(drive_q.size(), w);
      endfunction

      function void check_result(logic [JOINT_W-1:0] j, logic [Q_W-1:0] d);
         drive_word_type w;
         if (drive_q.size() == 0) begin
            $display("%0t: unexpected drive word, joint %0d drive %h", $time, j, d);
            errors++;
            return;
         end
         w = drive_q.pop_front();
         if (j !== w.joint) begin
            $display("%0t: joint_out mismatch, expected %0d actual %0d", $time, w.joint, j);
            errors++;
         end
         if (d !== w.drive) begin
            $display("%0t: drive mismatch on joint %0d, expected %h actual %h",
                     $time, w.joint, w.drive, d);
            errors++;
         end
      endfunction

      function int pending();
         return drive_q.size();
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   mjpid_req_if req_bus();
   mjpid_rsp_if rsp_bus();

   pid_scoreboard_type sb;
   bit                 steady;
   int                 words_sent;
   int                 rsp_stall;
   int                 idle_cycles;

   multi_joint_pid_controller u_dut (
      .clock   (clock),
      .reset   (reset),
      .req     (req_bus),
      .rsp     (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall = 0;
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            sb.check_result(rsp_bus.joint_out, rsp_bus.drive);
            rsp_stall = steady ? 0 : $urandom_range(0, 19);
         end else if (rsp_bus.valid && rsp_stall > 0) begin
            rsp_stall--;
         end
         rsp_bus.ready <= (rsp_stall == 0);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
          || (psel && penable && pready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      while (idle_cycles < STALL_LIMIT) @(posedge clock);
      $display("TEST FAILED");
      $finish;
   end

   task automatic send_word(word_kind_type kind, logic [JOINT_W-1:0] joint,
                            logic [Q_W-1:0] value, logic [Q_W-1:0] bias);
      int gap;
      gap = steady ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.cmd <= kind;
      req_bus.joint <= joint;
      req_bus.value <= value;
      req_bus.bias_torque <= bias;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      sb.note_word(kind, joint, value, bias);
      words_sent++;
   endtask

   task automatic csr_write(csr_index_type idx, logic [31:0] data);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= CSR_ADDR_W'(int'(idx) * 4);
      pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      sb.write_reg(idx, data);
   endtask

   // Registers change only once the block has gone quiet; a velocity command
   // leaves no response behind, so some extra cycles follow the last drive word.
   task automatic configure(ctrl_mode_type mode, logic [31:0] p_gain, logic [31:0] i_gain,
                            logic [31:0] d_gain, logic [15:0] rate);
      req_bus.valid <= 1'b0;
      while (sb.pending() > 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_write(REG_MODE, 32'(mode));
      csr_write(REG_KP, p_gain);
      csr_write(REG_KI, i_gain);
      csr_write(REG_KD, d_gain);
      csr_write(REG_RATE, 32'(rate));
      psel <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [31:0] pick_gain();
      logic [31:0] g;
      case ($urandom_range(0, 5))
         0: g = 32'h0;
         1: g = 32'hffff_ffff;
         2: g = $urandom;
         default: g = $urandom_range(0, 32'h0004_0000);
      endcase
      return g;
   endfunction

   function automatic logic [15:0] pick_rate();
      logic [15:0] r;
      case ($urandom_range(0, 5))
         0: r = 16'($urandom_range(0, 1));
         1: r = 16'hffff;
         2: r = 16'd1000;
         default: r = 16'($urandom_range(1, 200));
      endcase
      return r;
   endfunction

   function automatic logic [31:0] pick_q();
      logic [31:0] q;
      case ($urandom_range(0, 7))
         0: begin
            case ($urandom_range(0, 4))
               0: q = Q_HI;
               1: q = Q_LO;
               2: q = 32'h0;
               3: q = 32'hffff_ffff;
               default: q = 32'h1;
            endcase
         end
         1: q = $urandom;
         default: q = 32'($urandom_range(0, 32'h0040_0000)) - 32'h0020_0000;
      endcase
      return q;
   endfunction

   task automatic run_random_phase();
      int            n;
      int            pick;
      ctrl_mode_type mode;
      word_kind_type kind;
      pick = $urandom_range(0, 9);
      if (pick < 4) mode = MODE_POSITION;
      else if (pick < 7) mode = MODE_VELOCITY;
      else if (pick < 9) mode = MODE_TORQUE;
      else mode = MODE_UNKNOWN;
      configure(mode, pick_gain(), pick_gain(), pick_gain(), pick_rate());
      steady = ($urandom_range(0, 3) == 0);
      n = $urandom_range(40, 120);
      repeat (n) begin
         kind = ($urandom_range(0, 3) == 0) ? CMD_SET : CMD_TICK;
         send_word(kind, JOINT_W'($urandom_range(0, 7)), pick_q(), pick_q());
      end
   endtask

   initial begin
      sb = new();
      words_sent = 0;
      steady = 1'b0;
      reset <= 1'b1;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= '0;
      pwdata <= '0;
      req_bus.valid <= 1'b0;
      req_bus.cmd <= 1'b0;
      req_bus.joint <= '0;
      req_bus.value <= '0;
      req_bus.bias_torque <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // With the reset gains every drive is zero.
      send_word(CMD_TICK, 3'd0, Q_HI, 32'h0);

      // Position mode, unity Kp, full Ki and Kd: error and integral saturate.
      configure(MODE_POSITION, 32'h0001_0000, 32'hffff_ffff, 32'hffff_ffff, 16'd1);
      send_word(CMD_SET, 3'd1, Q_HI, 32'h0);
      send_word(CMD_TICK, 3'd1, Q_LO, Q_HI);
      send_word(CMD_TICK, 3'd1, Q_HI, Q_LO);
      send_word(CMD_SET, 3'd2, Q_LO, 32'h0);
      send_word(CMD_TICK, 3'd2, Q_HI, 32'h0);
      send_word(CMD_TICK, 3'd2, 32'h0, 32'h0);

      // A zero sample rate behaves as one; the velocity reference saturates.
      configure(MODE_VELOCITY, 32'h0000_8000, 32'h0000_0001, 32'h0, 16'd0);
      send_word(CMD_SET, 3'd3, Q_HI, 32'h0);
      send_word(CMD_SET, 3'd3, Q_HI, 32'h0);
      send_word(CMD_TICK, 3'd3, 32'h0, 32'h0);
      send_word(CMD_SET, 3'd3, Q_LO, 32'h0);
      send_word(CMD_TICK, 3'd3, 32'hffff_ffff, 32'h0);

      // Division by the highest rate truncates small steps toward zero.
      configure(MODE_VELOCITY, 32'hffff_ffff, 32'h0, 32'h1, 16'hffff);
      send_word(CMD_SET, 3'd4, 32'hffff_fffb, 32'h0);
      send_word(CMD_SET, 3'd4, 32'h1234_5678, 32'h0);
      send_word(CMD_TICK, 3'd4, 32'h0000_0001, 32'hffff_ffff);
      send_word(CMD_TICK, 3'd4, 32'hfedc_ba98, 32'h0);

      // Torque mode adds bias to the reference torque and keeps the PID history.
      configure(MODE_TORQUE, 32'h0, 32'h0, 32'h0, 16'd1000);
      send_word(CMD_SET, 3'd5, Q_HI, 32'h0);
      send_word(CMD_TICK, 3'd5, 32'h1234_0000, Q_HI);
      send_word(CMD_TICK, 3'd5, Q_LO, Q_LO);
      send_word(CMD_TICK, 3'd6, Q_HI, 32'hffff_ffff);

      // The unknown mode ignores commands and drives zero.
      configure(MODE_UNKNOWN, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 16'd1);
      send_word(CMD_SET, 3'd6, 32'd123, 32'h0);
      send_word(CMD_TICK, 3'd6, Q_LO, Q_HI);

      configure(MODE_POSITION, 32'h0002_0000, 32'h0000_1000, 32'h0000_0100, 16'd50);
      send_word(CMD_TICK, 3'd5, 32'h0, 32'h0);
      send_word(CMD_TICK, 3'd6, 32'h0, 32'h0);
      send_word(CMD_TICK, 3'd7, Q_LO, Q_LO);

      while (words_sent < RANDOM_WORDS + 25) run_random_phase();

      req_bus.valid <= 1'b0;
      while (sb.pending() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/mjpid_pkg.sv
hw/rtl/mjpid_req_if.sv
hw/rtl/mjpid_rsp_if.sv
hw/rtl/multi_joint_pid_controller.sv
tb/tb_multi_joint_pid_controller.sv
